// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CHK_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CHK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/nswg_pkg.sv =====
// Types and constants of the nonuniform stencil weight generator.
package nswg_pkg;

  localparam int MAX_POINTS_DEF = 4096;
  localparam int OP_W           = 36;   // distance sums, all below 2^35
  localparam int WIDE_W         = 128;  // product, remainder and quotient width
  localparam int MUL_STEPS      = OP_W;
  localparam int DIV_STEPS      = WIDE_W;
  localparam int SHIFT_FIRST    = 49;
  localparam int SHIFT_SECOND   = 67;
  localparam int ROW_W          = 12;
  localparam int WGT_W          = 64;
  localparam int OUT_DATA_W     = 272;
  localparam int CFG_ADDR_W     = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_DERIV_ORDER = 3'd0;

  localparam logic [WGT_W-1:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WGT_W-1:0] S64_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL1   = 7'b0000010,
    ST_MUL2   = 7'b0000100,
    ST_MULN   = 7'b0001000,
    ST_DIV    = 7'b0010000,
    ST_WSTORE = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    WK_ALPHA = 2'd0,
    WK_BETA  = 2'd1,
    WK_GAMMA = 2'd2
  } wkind_t;

endpackage

// ===== rtl/nonuniform_stencil_weight_generator.sv =====
// Stencil weight generator for nonuniform grids, with its sequencer and shared datapath.
//
// Input stream (s_*): one beat carries one grid spacing (unsigned Q16.16) in
// s_tdata; s_tuser set marks the first spacing of a new grid. Output stream
// (m_*): one beat per stencil row, the row index and four signed Q32.32
// weights in m_tdata, the zero-denominator flag in m_tuser.
// The first three spacings of a grid only fill the window.
// From the fourth spacing on each beat yields one row. Spacings beyond
// MAX_POINTS in one grid are dropped until a new grid starts.
// Every row runs through one shared 128-bit adder/subtractor: per weight two
// 36-step shift-add multiplies for the denominator, a third for the
// numerator in first-derivative mode, then a 128-step restoring division and
// a saturation step. A row with a zero denominator skips this work and is
// emitted with the fault flag set. s_tready is low while a row is worked.
// The finished row sits in an output register; a stalled receiver holds it
// there while the next spacing is already accepted, and the following row
// waits at the end of its computation until the register is free.
// Reset (rst, synchronous) clears the window, the count and the mode register
// (first derivative). The mode register sits at byte address 0 on the APB port.
module nonuniform_stencil_weight_generator
  import nswg_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [31:0]             s_tdata,   // [31:0] spacing
  input  logic                    s_tuser,   // [0] grid_start
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // [11:0] row_index, [75:12] weight_far_left, [139:76] weight_near_left,
  // [203:140] weight_centre, [267:204] weight_right, [271:268] zero
  output logic [OUT_DATA_W-1:0]   m_tdata,
  output logic                    m_tuser    // [0] divide_fault
);

`include "assert_macros.svh"

  localparam int CLOG_PTS = $clog2(MAX_POINTS + 1);
  localparam int CNT_W    = (CLOG_PTS > ROW_W) ? CLOG_PTS : ROW_W;

  state_t              state;
  logic                deriv_order;
  logic [31:0]         win [3];
  logic [CNT_W-1:0]    seen;

  logic [OP_W-1:0]     op_a, op_b, op_c, op_amb, op_apc, op_bpc, op_apb;
  logic [1:0]          wk;
  logic                fault;
  logic [WGT_W-1:0]    wgt [3];

  logic [WIDE_W-1:0]   acc, mcand, den, numr, quo;
  logic [OP_W-1:0]     mlt;
  logic [6:0]          cnt;

  // configuration port
  logic reg_hit;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_DERIV_ORDER[CFG_ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {31'b0, deriv_order} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      deriv_order <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      deriv_order <= pwdata[0];
    end
  end

  // input side
  logic              in_acc;
  logic [CNT_W-1:0]  eff_seen;
  logic [31:0]       e0, e1, e2;
  logic [OP_W-1:0]   na, nb, nc, namb;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign eff_seen = s_tuser ? '0 : seen;
  assign e0       = s_tuser ? 32'd0 : win[0];
  assign e1       = s_tuser ? 32'd0 : win[1];
  assign e2       = s_tuser ? 32'd0 : win[2];
  assign na       = OP_W'(e0) + OP_W'({e1, 1'b0}) + OP_W'(e2);
  assign nb       = OP_W'(e1) + OP_W'(e2);
  assign nc       = OP_W'(e2) + OP_W'(s_tdata);
  assign namb     = OP_W'(e0) + OP_W'(e1);

  // operand selection per weight
  logic [OP_W-1:0] f3, g1, g2, mag;
  logic            wneg;

  always_comb begin
    unique case (wkind_t'(wk))
      WK_ALPHA: begin
        f3 = op_amb;
        g1 = op_b;   g2 = op_c;
        mag  = (op_c >= op_b) ? op_c - op_b : op_b - op_c;
        wneg = deriv_order && (op_c < op_b);
      end
      WK_BETA: begin
        f3 = op_bpc;
        g1 = op_a;   g2 = op_c;
        mag  = (op_a >= op_c) ? op_a - op_c : op_c - op_a;
        wneg = deriv_order ? (op_a < op_c) : 1'b1;
      end
      default: begin
        f3 = op_apc;
        g1 = op_a;   g2 = op_b;
        mag  = op_apb;
        wneg = 1'b0;
      end
    endcase
  end

  // shared adder: add in the multiplies, compare and subtract in the division
  logic [WIDE_W-1:0] rem_sh, add_a, add_b, acc_mul;
  logic              add_sub, ge;
  logic [WIDE_W:0]   add_res;

  assign rem_sh  = {acc[WIDE_W-2:0], numr[WIDE_W-1]};
  assign add_sub = (state == ST_DIV);
  assign add_a   = add_sub ? rem_sh : acc;
  assign add_b   = add_sub ? den : mcand;
  assign add_res = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b} + (WIDE_W+1)'(add_sub);
  assign ge      = add_res[WIDE_W];
  assign acc_mul = mlt[0] ? add_res[WIDE_W-1:0] : acc;

  // saturated weight from the quotient
  logic [WGT_W-1:0] wsat;
  always_comb begin
    if (wneg) begin
      if ((|quo[WIDE_W-1:WGT_W]) || quo[WGT_W-1:0] > S64_MIN) wsat = S64_MIN;
      else                                                   wsat = -quo[WGT_W-1:0];
    end else begin
      if (|quo[WIDE_W-1:WGT_W-1]) wsat = S64_MAX;
      else                        wsat = quo[WGT_W-1:0];
    end
  end

  // centre weight: negated sum, saturated
  logic signed [WGT_W+1:0] csum, cneg;
  logic [WGT_W-1:0]        wcen;
  assign csum = (WGT_W+2)'($signed(wgt[0])) + (WGT_W+2)'($signed(wgt[1]))
              + (WGT_W+2)'($signed(wgt[2]));
  assign cneg = -csum;
  always_comb begin
    if (cneg > $signed({2'b00, S64_MAX}))      wcen = S64_MAX;
    else if (cneg < $signed({2'b11, S64_MIN})) wcen = S64_MIN;
    else                                       wcen = cneg[WGT_W-1:0];
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seen     <= '0;
      win[0]   <= '0;
      win[1]   <= '0;
      win[2]   <= '0;
      m_tvalid <= 1'b0;
      wk       <= 2'd0;
      fault    <= 1'b0;
      cnt      <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_EMIT) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_acc && eff_seen < CNT_W'(MAX_POINTS)) begin
            win[0] <= e1;
            win[1] <= e2;
            win[2] <= s_tdata;
            seen   <= eff_seen + 1'b1;
            if (eff_seen >= CNT_W'(3)) begin
              op_a   <= na;
              op_b   <= nb;
              op_c   <= nc;
              op_amb <= namb;
              op_apc <= na + nc;
              op_bpc <= nb + nc;
              op_apb <= na + nb;
              wk     <= 2'd0;
              cnt    <= '0;
              acc    <= '0;
              wgt[0] <= '0;
              wgt[1] <= '0;
              wgt[2] <= '0;
              if (na == '0 || nb == '0 || nc == '0 || namb == '0) begin
                fault <= 1'b1;
                state <= ST_EMIT;
              end else begin
                fault <= 1'b0;
                mcand <= WIDE_W'(na);
                mlt   <= na + nc;
                state <= ST_MUL1;
              end
            end
          end
        end
        ST_MUL1, ST_MUL2, ST_MULN: begin
          if (cnt == 7'(MUL_STEPS - 1)) begin
            cnt <= '0;
            acc <= '0;
            if (state == ST_MUL1) begin
              mcand <= acc_mul;
              mlt   <= f3;
              state <= ST_MUL2;
            end else if (state == ST_MUL2) begin
              den <= acc_mul;
              if (deriv_order) begin
                numr  <= WIDE_W'(mag) << SHIFT_SECOND;
                state <= ST_DIV;
              end else begin
                mcand <= WIDE_W'(g1);
                mlt   <= g2;
                state <= ST_MULN;
              end
            end else begin
              numr  <= acc_mul << SHIFT_FIRST;
              state <= ST_DIV;
            end
          end else begin
            acc   <= acc_mul;
            mcand <= {mcand[WIDE_W-2:0], 1'b0};
            mlt   <= mlt >> 1;
            cnt   <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          acc  <= ge ? add_res[WIDE_W-1:0] : rem_sh;
          quo  <= {quo[WIDE_W-2:0], ge};
          numr <= {numr[WIDE_W-2:0], 1'b0};
          cnt  <= cnt + 1'b1;
          if (cnt == 7'(DIV_STEPS - 1)) begin
            state <= ST_WSTORE;
          end
        end
        ST_WSTORE: begin
          wgt[wk] <= wsat;
          cnt     <= '0;
          acc     <= '0;
          if (wk == 2'(WK_GAMMA)) begin
            state <= ST_EMIT;
          end else begin
            // first factor pair of the next weight
            mcand <= WIDE_W'(wk == 2'(WK_ALPHA) ? op_b : op_c);
            mlt   <= (wk == 2'(WK_ALPHA)) ? op_amb : op_bpc;
            wk    <= wk + 1'b1;
            state <= ST_MUL1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {4'b0, wgt[2], wcen, wgt[1], wgt[0], ROW_W'(seen - CNT_W'(4))};
      m_tuser <= fault;
    end
  end

  `CHK_PROP(a_fault_zero, clk, rst, m_tvalid && m_tuser |-> m_tdata[267:12] == '0, "fault weights")
  `CHK_PROP(a_count_bound, clk, rst, seen <= CNT_W'(MAX_POINTS), "count beyond MAX_POINTS")
  `CHK_PROP(a_emit_origin, clk, rst, $rose(m_tvalid) |-> $past(state == ST_EMIT), "stray row")

endmodule
